>>> design/pending_packet_queue_by_address_defines.svh
// assertion macros for the pending packet queue
// used by the top level only; needs nothing else
`ifndef PENDING_PACKET_QUEUE_BY_ADDRESS_DEFINES_SVH
`define PENDING_PACKET_QUEUE_BY_ADDRESS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppq check failed");

// next-cycle implication, checked outside reset
`define PPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppq check failed");

`endif

>>> design/ppq_pkg.sv
// shared types, operation codes and defaults for the pending packet queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ppq_pkg;

   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int MAX_PAYLOAD_DEF = 1500;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_REMOVE  = 2'd1;
   localparam logic [1:0] OP_COUNT   = 2'd2;

   localparam logic [3:0] COUNT_MAX = 4'd15;

   // one queued descriptor
   typedef struct packed {
      logic [31:0] address;
      logic [15:0] ethertype;
      logic [10:0] body_len;
      logic [15:0] payload_ref;
   } entry_type;

   // one result beat
   typedef struct packed {
      logic        ok;
      logic [15:0] ethertype;
      logic [10:0] body_len;
      logic [15:0] payload_ref;
      logic [3:0]  match_count;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/ppq_mem.sv
// descriptor store: one write port, one read port with registered read data
// depends on ppq_pkg for the entry layout
`timescale 1ns / 1ps
`default_nettype none

module ppq_mem #(
   parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire ppq_pkg::entry_type wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output ppq_pkg::entry_type      rd_data
);

   ppq_pkg::entry_type mem [QUEUE_DEPTH];
   ppq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/ppq_ctrl.sv
// queue sequencer: enqueue, rotating remove scan and count scan over ppq_mem
// depends on ppq_pkg and ppq_mem
`timescale 1ns / 1ps
`default_nettype none

module ppq_ctrl #(
   parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_PAYLOAD = ppq_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_operation,
   input  wire logic [31:0]   req_dest_addr,
   input  wire logic [15:0]   req_ethertype,
   input  wire logic [10:0]   req_body_len,
   input  wire logic [15:0]   req_payload_ref,
   output logic               res_valid,
   output ppq_pkg::rsp_type   res,
   input  wire logic          res_take
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_POST = 2'd2;

   function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      if (p == AW'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + AW'(1);
      end
      return r;
   endfunction

   logic [1:0]          state_ff, state_in;
   logic [AW-1:0]       rd_ff, rd_in;
   logic [AW-1:0]       wr_ff, wr_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic                rvalid_ff, rvalid_in;
   logic [1:0]          op_ff, op_in;
   logic [31:0]         key_ff, key_in;
   logic [FW-1:0]       len_ff, len_in;
   logic [FW-1:0]       iss_ff, iss_in;
   logic [FW-1:0]       proc_ff, proc_in;
   logic [AW-1:0]       scan_ptr_ff, scan_ptr_in;
   ppq_pkg::rsp_type    res_ff, res_in;

   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   ppq_pkg::entry_type  mem_wr_data;
   logic                mem_rd_en;
   ppq_pkg::entry_type  mem_rd_data;
   ppq_pkg::entry_type  req_entry;
   logic                accept;
   logic                hit;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign res_valid = (state_ff == ST_POST);
   assign res       = res_ff;
   assign hit       = (mem_rd_data.address == key_ff);

   always_comb begin
      req_entry.address     = req_dest_addr;
      req_entry.ethertype   = req_ethertype;
      req_entry.body_len    = req_body_len;
      req_entry.payload_ref = req_payload_ref;
   end

   always_comb begin
      state_in    = state_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      fill_in     = fill_ff;
      rvalid_in   = 1'b0;
      op_in       = op_ff;
      key_in      = key_ff;
      len_in      = len_ff;
      iss_in      = iss_ff;
      proc_in     = proc_ff;
      scan_ptr_in = scan_ptr_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = wr_ff;
      mem_wr_data = req_entry;
      mem_rd_en   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_operation;
               key_in = req_dest_addr;
               res_in = '0;
               case (req_operation)
                  ppq_pkg::OP_ENQUEUE: begin
                     if (fill_ff < FW'(QUEUE_DEPTH) &&
                         req_body_len <= 11'(MAX_PAYLOAD)) begin
                        mem_wr_en = 1'b1;
                        wr_in     = slot_inc(wr_ff);
                        fill_in   = fill_ff + FW'(1);
                        res_in.ok = 1'b1;
                     end
                     state_in = ST_POST;
                  end
                  ppq_pkg::OP_REMOVE, ppq_pkg::OP_COUNT: begin
                     if (fill_ff == '0) begin
                        state_in = ST_POST;
                     end else begin
                        len_in      = fill_ff;
                        iss_in      = '0;
                        proc_in     = '0;
                        scan_ptr_in = rd_ff;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_POST;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue side: one read per cycle until every entry is fetched
            if (iss_ff != len_ff) begin
               mem_rd_en   = 1'b1;
               scan_ptr_in = slot_inc(scan_ptr_ff);
               iss_in      = iss_ff + FW'(1);
               if (op_ff == ppq_pkg::OP_REMOVE) begin
                  rd_in = slot_inc(scan_ptr_ff);
               end
            end
            rvalid_in = mem_rd_en;
            // process side: handles each entry in the cycle after its read
            if (rvalid_ff) begin
               proc_in = proc_ff + FW'(1);
               if (op_ff == ppq_pkg::OP_REMOVE) begin
                  if (!res_ff.ok && hit) begin
                     res_in.ok          = 1'b1;
                     res_in.ethertype   = mem_rd_data.ethertype;
                     res_in.body_len    = mem_rd_data.body_len;
                     res_in.payload_ref = mem_rd_data.payload_ref;
                     fill_in            = fill_ff - FW'(1);
                  end else begin
                     // re-append behind the tail, keeping order
                     mem_wr_en   = 1'b1;
                     mem_wr_data = mem_rd_data;
                     wr_in       = slot_inc(wr_ff);
                  end
               end else if (hit && res_ff.match_count != ppq_pkg::COUNT_MAX) begin
                  res_in.match_count = res_ff.match_count + 4'd1;
               end
               if (proc_ff == len_ff - FW'(1)) begin
                  state_in = ST_POST;
               end
            end
         end
         ST_POST: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_ff     <= '0;
         wr_ff     <= '0;
         fill_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ff     <= rd_in;
         wr_ff     <= wr_in;
         fill_ff   <= fill_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      len_ff      <= len_in;
      iss_ff      <= iss_in;
      proc_ff     <= proc_in;
      scan_ptr_ff <= scan_ptr_in;
      res_ff      <= res_in;
   end

   ppq_mem #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (scan_ptr_ff),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

>>> design/pending_packet_queue_by_address.sv
// channel  dir  handshake          payload
// req      in   req_valid/stall    operation, dest_addr, ethertype, body_len, payload_ref
// rsp      out  rsp_valid/stall    ok, out_ethertype, out_body_len, out_payload_ref, match_count
//
// enqueue, the unused code and a scan of an empty queue: the result goes from accept straight
// to the post state and then into the rsp register
// remove and count: the scan reads every entry; the descriptor ram yields one entry per cycle
// one request in flight; req_stall is high from accept until the result enters the rsp register
// reset empties the queue; ram contents are not cleared
// rsp register lets a new request start while the previous beat waits on rsp_stall
`timescale 1ns / 1ps
`default_nettype none

`include "pending_packet_queue_by_address_defines.svh"

module pending_packet_queue_by_address #(
   parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_PAYLOAD = ppq_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_operation,
   input  wire logic [31:0]   req_dest_addr,
   input  wire logic [15:0]   req_ethertype,
   input  wire logic [10:0]   req_body_len,
   input  wire logic [15:0]   req_payload_ref,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_ok,
   output logic [15:0]        rsp_out_ethertype,
   output logic [10:0]        rsp_out_body_len,
   output logic [15:0]        rsp_out_payload_ref,
   output logic [3:0]         rsp_match_count
);

   logic              res_valid;
   ppq_pkg::rsp_type  res;
   logic              res_take;
   logic              rsp_valid_ff, rsp_valid_in;
   ppq_pkg::rsp_type  rsp_ff, rsp_in;

   ppq_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_dest_addr   (req_dest_addr),
      .req_ethertype   (req_ethertype),
      .req_body_len    (req_body_len),
      .req_payload_ref (req_payload_ref),
      .res_valid       (res_valid),
      .res             (res),
      .res_take        (res_take)
   );

   // output register frees when empty or when the current beat is taken
   assign res_take     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = (res_valid && res_take) || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = (res_valid && res_take) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = rsp_ff.ok;
   assign rsp_out_ethertype   = rsp_ff.ethertype;
   assign rsp_out_body_len    = rsp_ff.body_len;
   assign rsp_out_payload_ref = rsp_ff.payload_ref;
   assign rsp_match_count     = rsp_ff.match_count;

   // a finished result that cannot move on must still be there next cycle
   `PPQ_ASSERT_NEXT(a_res_held, clock, reset, res_valid && !res_take, res_valid)
   // no new request while a result is still parked in the sequencer
   `PPQ_ASSERT_NOW(a_no_accept_pending, clock, reset, req_valid && !req_stall, !res_valid)
   // a count beat never reports ok, other beats never carry a count
   `PPQ_ASSERT_NOW(a_ok_xor_count, clock, reset, rsp_valid, !(rsp_ok && rsp_match_count != 4'd0))

endmodule

`default_nettype wire
